[sv/srlp_pkg.sv]
// srlp_pkg: shared types and codes for the sector run list parser
// result kinds, result entry and parser step record; no dependencies
`default_nettype none

package srlp_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned KindW  = 2;

  localparam logic [KindW-1:0] KIND_RUN    = 2'd0;
  localparam logic [KindW-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KindW-1:0] KIND_REJECT = 2'd2;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] start;
    logic [ValueW-1:0] count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              emit_run;
    logic              emit_end;
    logic [KindW-1:0]  end_kind;
    logic [ValueW-1:0] run_start;
    logic [ValueW-1:0] run_count;
  } step_t;

endpackage

`default_nettype wire

[sv/sector_run_list_parser.sv]
// sector_run_list_parser: top level, parser plus two-entry result queue
// depends on srlp_pkg and srlp_parser
//
//   channel | signals                                          | direction
//   in      | in_valid, in_stall, char_in, last_char           | into block
//   out     | out_valid, out_stall, item_kind, start_sector,   | out of block
//           | sector_count, last_result                        |
//
// one character per cycle while in_stall is low; a character that closes a pair on the last
// character yields two transactions and holds the input while both results are queued
// results appear in the cycle after the character is taken, from the queue head
// in_stall is high while the queue cannot drain to empty in the same cycle
// rst is synchronous: parse state returns to expecting the opening bracket
`default_nettype none

module sector_run_list_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                char_in,
  input  wire logic                      last_char,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [srlp_pkg::KindW-1:0]     item_kind,
  output logic [srlp_pkg::ValueW-1:0]    start_sector,
  output logic [srlp_pkg::ValueW-1:0]    sector_count,
  output logic                           last_result
);
  import srlp_pkg::*;

  step_t      step;
  result_t    q0, q1;
  result_t    res_run, res_end;
  logic [1:0] q_count;
  logic       accept, pop;

  assign out_valid = (q_count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (q_count == 2'd2) || ((q_count == 2'd1) && !pop);
  assign accept    = in_valid && !in_stall;

  srlp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_in   (char_in),
    .last_char (last_char),
    .step      (step)
  );

  assign res_run = '{kind: KIND_RUN, start: step.run_start, count: step.run_count,
                     last: !step.emit_end};
  assign res_end = '{kind: step.end_kind, start: '0, count: '0, last: 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else if (accept) begin
      q_count <= 2'(step.emit_run) + 2'(step.emit_end);
      q0      <= step.emit_run ? res_run : res_end;
      q1      <= res_end;
    end else if (pop) begin
      q_count <= q_count - 2'd1;
      q0      <= q1;
    end
  end

  assign item_kind    = q0.kind;
  assign start_sector = q0.start;
  assign sector_count = q0.count;
  assign last_result  = q0.last;

  a_accept_drains: assert property (@(posedge clk) disable iff (rst)
    accept |-> (q_count == 2'd0 || pop))
    else $error("input taken while queue cannot drain");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind != KIND_RUN) |-> last_result)
    else $error("end transaction without last_result");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (q_count == 2'd2) |-> (q0.kind == KIND_RUN && !q0.last && q1.last))
    else $error("two queued results not a run followed by an end");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_count != 2'd3)
    else $error("queue count out of range");

endmodule

`default_nettype wire

[sv/srlp_parser.sv]
// srlp_parser: parse state, field accumulators and per-character decision
// depends on srlp_pkg
`default_nettype none

module srlp_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    char_in,
  input  wire logic          last_char,
  output srlp_pkg::step_t    step
);
  import srlp_pkg::*;

  typedef enum logic [3:0] {
    MODE_OPEN, MODE_BETWEEN, MODE_PAIR, MODE_START, MODE_COUNT0,
    MODE_COUNT, MODE_TRAIL, MODE_ACCEPT, MODE_REJECT
  } mode_t;

  mode_t              mode, mode_next, mode_step;
  logic [ValueW-1:0]  start_value, start_next;
  logic [ValueW-1:0]  acc, acc_next;
  logic [ValueW+3:0]  acc_wide;
  logic [ValueW+3:0]  push_sum;
  logic [3:0]         digit;
  logic               is_digit, is_white, ovf;
  mode_t              tail;

  assign digit    = 4'(char_in - CH_ZERO);
  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_white = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
  assign acc_wide = {4'b0, acc};
  assign push_sum = (acc_wide << 3) + (acc_wide << 1) + {{ValueW{1'b0}}, digit};
  assign ovf      = |push_sum[ValueW+3:ValueW];

  always_comb begin
    if (char_in == CH_CLOSE) begin
      tail = MODE_ACCEPT;
    end else if (is_white) begin
      tail = MODE_TRAIL;
    end else begin
      tail = MODE_REJECT;
    end
  end

  always_comb begin
    mode_step      = mode;
    start_next     = start_value;
    acc_next       = acc;
    step.emit_run  = 1'b0;
    step.run_start = start_value;
    step.run_count = acc;
    unique case (mode)
      MODE_OPEN: begin
        mode_step = (char_in == CH_OPEN) ? MODE_BETWEEN : MODE_REJECT;
      end
      MODE_BETWEEN: begin
        if (char_in != CH_SPACE && char_in != CH_COMMA) begin
          mode_step = (char_in == CH_OPEN) ? MODE_PAIR : tail;
        end
      end
      MODE_PAIR: begin
        if (is_digit) begin
          acc_next  = {{(ValueW-4){1'b0}}, digit};
          mode_step = MODE_START;
        end else begin
          mode_step = tail;
        end
      end
      MODE_START: begin
        if (is_digit) begin
          if (ovf) begin
            mode_step = MODE_REJECT;
          end else begin
            acc_next = push_sum[ValueW-1:0];
          end
        end else if (char_in == CH_COMMA) begin
          start_next = acc;
          acc_next   = '0;
          mode_step  = MODE_COUNT0;
        end else begin
          mode_step = MODE_REJECT;
        end
      end
      MODE_COUNT0: begin
        if (is_digit) begin
          acc_next  = push_sum[ValueW-1:0];
          mode_step = MODE_COUNT;
        end else begin
          mode_step = MODE_REJECT;
        end
      end
      MODE_COUNT: begin
        if (is_digit) begin
          if (ovf) begin
            mode_step = MODE_REJECT;
          end else begin
            acc_next = push_sum[ValueW-1:0];
          end
        end else if (char_in == CH_CLOSE && acc != '0) begin
          step.emit_run = 1'b1;
          mode_step     = MODE_BETWEEN;
        end else begin
          mode_step = MODE_REJECT;
        end
      end
      MODE_TRAIL: begin
        if (!is_white) begin
          mode_step = (char_in == CH_CLOSE) ? MODE_ACCEPT : MODE_REJECT;
        end
      end
      MODE_ACCEPT: begin
      end
      MODE_REJECT: begin
      end
      default: begin
        mode_step = MODE_REJECT;
      end
    endcase

    step.emit_end = last_char;
    if (mode_step == MODE_BETWEEN || mode_step == MODE_PAIR ||
        mode_step == MODE_TRAIL || mode_step == MODE_ACCEPT) begin
      step.end_kind = KIND_ACCEPT;
    end else begin
      step.end_kind = KIND_REJECT;
    end
    mode_next = last_char ? MODE_OPEN : mode_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_OPEN;
      start_value <= '0;
      acc         <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      start_value <= last_char ? '0 : start_next;
      acc         <= last_char ? '0 : acc_next;
    end
  end

endmodule

`default_nettype wire
